/* sv/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, constants and size class helpers for the size class block
// allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

   localparam int CHUNK_BYTES     = 16384;
   localparam int MAX_CHUNKS      = 16;
   localparam int NUM_CLASSES     = 14;
   localparam int MAX_BLOCK_BYTES = 640;

   localparam int ADDR_W      = 18;
   localparam int SIZE_W      = 16;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);
   localparam int BLOCK_W     = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int CHUNK_OFS_W = $clog2(CHUNK_BYTES);
   localparam int CHUNK_CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam int LINK_DEPTH  = (MAX_CHUNKS * CHUNK_BYTES + 15) / 16;
   localparam int SLOT_W      = $clog2(LINK_DEPTH);

   // request codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // response codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_CHUNK = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
   } ptr_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      ptr_type           wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
   } link_cmd_type;

   function automatic logic [BLOCK_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
      logic [BLOCK_W-1:0] bytes;
      case (cls)
         4'd0:    bytes = BLOCK_W'(16);
         4'd1:    bytes = BLOCK_W'(32);
         4'd2:    bytes = BLOCK_W'(64);
         4'd3:    bytes = BLOCK_W'(96);
         4'd4:    bytes = BLOCK_W'(128);
         4'd5:    bytes = BLOCK_W'(160);
         4'd6:    bytes = BLOCK_W'(192);
         4'd7:    bytes = BLOCK_W'(224);
         4'd8:    bytes = BLOCK_W'(256);
         4'd9:    bytes = BLOCK_W'(320);
         4'd10:   bytes = BLOCK_W'(384);
         4'd11:   bytes = BLOCK_W'(448);
         4'd12:   bytes = BLOCK_W'(512);
         default: bytes = BLOCK_W'(640);
      endcase
      return bytes;
   endfunction

   // smallest class that holds the size; anything larger lands in the last class
   function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
      logic [CLASS_W-1:0] cls;
      cls = CLASS_W'(NUM_CLASSES - 1);
      for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
         if (size <= SIZE_W'(class_bytes(CLASS_W'(c)))) begin
            cls = CLASS_W'(c);
         end
      end
      return cls;
   endfunction

   function automatic logic [SLOT_W-1:0] link_slot(input logic [ADDR_W-1:0] addr);
      return SLOT_W'(addr[ADDR_W-1:4]);
   endfunction

endpackage

/* sv/scba_link_mem.sv */
// ----------------------------------------------------------------------------
// scba_link_mem
// Free list link store: one entry per 16-byte slot, one write port and one
// read port, read data registered.
// ----------------------------------------------------------------------------
module scba_link_mem (
   input  logic                  clock,
   input  scba_pkg::link_cmd_type cmd,
   output scba_pkg::ptr_type      rd_data
);

   scba_pkg::ptr_type links [scba_pkg::LINK_DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         links[cmd.wr_slot] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data <= links[cmd.rd_slot];
      end
   end

endmodule

/* sv/size_class_block_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_block_allocator
// Segregated free list block allocator: allocate, free and clear requests
// over fixed-size chunks, one response per request.
// ----------------------------------------------------------------------------
//   channel   ports                                    transfer when
//   request   start, busy, req_func/size/block_addr    start & !busy
//   response  rsp_valid, rsp_alloc_addr, rsp_status    rsp_valid (one cycle)
//
// The accept cycle issues the link memory read for the class head; the next
// cycle reads, updates and writes back, with busy high. The response appears
// in the cycle after that, while the next request may already be taken. The
// receiver cannot stall.
// Reset empties every list and chunk at once; link memory needs no clearing.
// ----------------------------------------------------------------------------
module size_class_block_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [scba_pkg::FUNC_W-1:0]     req_func,
   input  logic [scba_pkg::SIZE_W-1:0]     req_size,
   input  logic [scba_pkg::ADDR_W-1:0]     req_block_addr,
   output logic                            rsp_valid,
   output logic [scba_pkg::ADDR_W-1:0]     rsp_alloc_addr,
   output logic [scba_pkg::STATUS_W-1:0]   rsp_status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [scba_pkg::FUNC_W-1:0]  func_ff;
   logic [scba_pkg::SIZE_W-1:0]  size_ff;
   logic [scba_pkg::ADDR_W-1:0]  baddr_ff;
   logic [scba_pkg::CLASS_W-1:0] cls_ff;
   scba_pkg::ptr_type            head_ff;

   scba_pkg::ptr_type free_heads_ff [scba_pkg::NUM_CLASSES];
   scba_pkg::ptr_type carve_ff      [scba_pkg::NUM_CLASSES];
   logic [scba_pkg::CHUNK_CNT_W-1:0] chunks_ff;

   logic                            rsp_valid_ff;
   logic [scba_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [scba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                         accept;
   logic [scba_pkg::CLASS_W-1:0] cls_req;
   scba_pkg::ptr_type            head_sel;
   scba_pkg::link_cmd_type       link_cmd;
   scba_pkg::ptr_type            link_rd;

   // exec-cycle decisions
   logic                         do_clear, do_push, do_pop, do_carve, do_open;
   scba_pkg::ptr_type            carve_cur;
   logic [scba_pkg::ADDR_W-1:0]  carve_base;   // block handed out by carve or open
   logic [scba_pkg::BLOCK_W-1:0] bsize;
   logic [scba_pkg::CHUNK_OFS_W+1:0] carve_end;
   scba_pkg::ptr_type            carve_adv;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff == ST_EXEC);
   assign cls_req = scba_pkg::class_of(req_size);
   assign head_sel = free_heads_ff[cls_req];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // request decode in the exec cycle
   always_comb begin
      do_clear      = 1'b0;
      do_push       = 1'b0;
      do_pop        = 1'b0;
      do_carve      = 1'b0;
      do_open       = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = scba_pkg::STATUS_OK;
      carve_cur     = carve_ff[cls_ff];
      carve_base    = '0;
      unique case (func_ff) inside
         scba_pkg::FUNC_CLEAR: do_clear = 1'b1;
         scba_pkg::FUNC_ALLOC, scba_pkg::FUNC_FREE: begin
            if (size_ff == '0) begin
               rsp_status_in = scba_pkg::STATUS_ZERO;
            end else if (size_ff > scba_pkg::SIZE_W'(scba_pkg::MAX_BLOCK_BYTES)) begin
               rsp_status_in = scba_pkg::STATUS_OVERSIZE;
            end else if (func_ff == scba_pkg::FUNC_FREE) begin
               do_push = 1'b1;
            end else if (head_ff.valid) begin
               do_pop      = 1'b1;
               rsp_addr_in = head_ff.addr;
            end else if (carve_cur.valid) begin
               do_carve    = 1'b1;
               carve_base  = carve_cur.addr;
               rsp_addr_in = carve_cur.addr;
            end else if (chunks_ff < scba_pkg::CHUNK_CNT_W'(scba_pkg::MAX_CHUNKS)) begin
               do_open     = 1'b1;
               carve_base  = scba_pkg::ADDR_W'({chunks_ff,
                                                 {scba_pkg::CHUNK_OFS_W{1'b0}}});
               rsp_addr_in = carve_base;
            end else begin
               rsp_status_in = scba_pkg::STATUS_NO_CHUNK;
            end
         end
         default: ;
      endcase
   end

   // next carve block, valid only if a whole block still fits in the chunk
   always_comb begin
      bsize     = scba_pkg::class_bytes(cls_ff);
      carve_end = (scba_pkg::CHUNK_OFS_W+2)'(carve_base[scba_pkg::CHUNK_OFS_W-1:0])
                + (scba_pkg::CHUNK_OFS_W+2)'({bsize, 1'b0});
      carve_adv.valid = (carve_end <= (scba_pkg::CHUNK_OFS_W+2)'(scba_pkg::CHUNK_BYTES));
      carve_adv.addr  = carve_adv.valid
                      ? carve_base + scba_pkg::ADDR_W'(bsize) : '0;
   end

   always_comb begin
      link_cmd.rd_en   = accept;
      link_cmd.rd_slot = scba_pkg::link_slot(head_sel.addr);
      link_cmd.wr_en   = busy && do_push;
      link_cmd.wr_slot = scba_pkg::link_slot(baddr_ff);
      link_cmd.wr_data = head_ff;
   end

   scba_link_mem u_link_mem (
      .clock   (clock),
      .cmd     (link_cmd),
      .rd_data (link_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= busy;
      end
   end

   // hold the request and the class head for the exec cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         size_ff  <= req_size;
         baddr_ff <= req_block_addr;
         cls_ff   <= cls_req;
         head_ff  <= head_sel;
      end
      if (busy) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            free_heads_ff[c].valid <= 1'b0;
            carve_ff[c].valid      <= 1'b0;
         end
         chunks_ff <= '0;
      end else if (busy) begin
         if (do_clear) begin
            for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
               free_heads_ff[c].valid <= 1'b0;
               carve_ff[c].valid      <= 1'b0;
            end
            chunks_ff <= '0;
         end
         if (do_push) begin
            free_heads_ff[cls_ff].valid <= 1'b1;
            free_heads_ff[cls_ff].addr  <= baddr_ff;
         end
         if (do_pop) begin
            free_heads_ff[cls_ff] <= link_rd;
         end
         if (do_carve || do_open) begin
            carve_ff[cls_ff] <= carve_adv;
         end
         if (do_open) begin
            chunks_ff <= chunks_ff + scba_pkg::CHUNK_CNT_W'(1);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_addr = rsp_addr_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

/* tb/sv/scba_checker.sv */
// ----------------------------------------------------------------------------
// scba_checker
// Watches the request and response channels of the size class block
// allocator, predicts each response from its own copy of the free lists,
// carve pointers and chunk count, and compares field by field.
// ----------------------------------------------------------------------------
module scba_checker
   import scba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [ADDR_W-1:0]   req_block_addr,
   input  logic                rsp_valid,
   input  logic [ADDR_W-1:0]   rsp_alloc_addr,
   input  logic [STATUS_W-1:0] rsp_status,
   output int                  errors,
   output int                  pending
);

   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
   } grant_type;

   ptr_type   list_head [NUM_CLASSES];
   ptr_type   carve_ptr [NUM_CLASSES];
   ptr_type   slot_link [LINK_DEPTH];
   int        chunks_open;
   grant_type expected_grants[$];
   int        mismatch_count = 0;

   assign errors = mismatch_count;

   function automatic int unsigned class_limit(input int cls);
      int unsigned bytes;
      case (cls)
         0:       bytes = 16;
         1:       bytes = 32;
         2:       bytes = 64;
         3:       bytes = 96;
         4:       bytes = 128;
         5:       bytes = 160;
         6:       bytes = 192;
         7:       bytes = 224;
         8:       bytes = 256;
         9:       bytes = 320;
         10:      bytes = 384;
         11:      bytes = 448;
         12:      bytes = 512;
         default: bytes = 640;
      endcase
      return bytes;
   endfunction

   function automatic int size_to_class(input logic [SIZE_W-1:0] size);
      int cls;
      cls = NUM_CLASSES - 1;
      for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
         if (size <= class_limit(c)) begin
            cls = c;
         end
      end
      return cls;
   endfunction

   // next block of the same chunk, or empty when it would run past the chunk
   function automatic ptr_type next_carve(input int cls, input logic [ADDR_W-1:0] addr);
      int unsigned bs;
      int unsigned base;
      int unsigned nxt;
      ptr_type     p;
      bs     = class_limit(cls);
      base   = (int'(addr) / CHUNK_BYTES) * CHUNK_BYTES;
      nxt    = int'(addr) + bs;
      p.valid = (nxt + bs <= base + CHUNK_BYTES);
      p.addr  = p.valid ? ADDR_W'(nxt) : '0;
      return p;
   endfunction

   task automatic predict_grant(input logic [FUNC_W-1:0] func,
                                input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] baddr);
      grant_type g;
      int        cls;
      g.addr   = '0;
      g.status = STATUS_OK;
      if (func == FUNC_CLEAR) begin
         foreach (list_head[c]) begin
            list_head[c] = '0;
            carve_ptr[c] = '0;
         end
         chunks_open = 0;
      end else if (func == FUNC_ALLOC || func == FUNC_FREE) begin
         cls = size_to_class(size);
         if (size == 0) begin
            g.status = STATUS_ZERO;
         end else if (size > MAX_BLOCK_BYTES) begin
            g.status = STATUS_OVERSIZE;
         end else if (func == FUNC_FREE) begin
            // push without any check; the link lives in the block's 16-byte slot
            slot_link[int'(baddr >> 4) % LINK_DEPTH] = list_head[cls];
            list_head[cls].valid = 1'b1;
            list_head[cls].addr  = baddr;
         end else if (list_head[cls].valid) begin
            g.addr = list_head[cls].addr;
            list_head[cls] = slot_link[int'(g.addr >> 4) % LINK_DEPTH];
         end else if (carve_ptr[cls].valid) begin
            g.addr = carve_ptr[cls].addr;
            carve_ptr[cls] = next_carve(cls, g.addr);
         end else if (chunks_open < MAX_CHUNKS) begin
            g.addr = ADDR_W'(chunks_open * CHUNK_BYTES);
            chunks_open++;
            carve_ptr[cls] = next_carve(cls, g.addr);
         end else begin
            g.status = STATUS_NO_CHUNK;
         end
      end
      expected_grants.push_back(g);
   endtask

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         foreach (list_head[c]) begin
            list_head[c] = '0;
            carve_ptr[c] = '0;
         end
         chunks_open = 0;
         expected_grants.delete();
      end else begin
         // compare the response before counting a transfer on the same edge
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               $error("response with nothing expected: alloc_addr 0x%05h status %0d",
                      rsp_alloc_addr, rsp_status);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_alloc_addr !== want.addr) begin
                  $error("alloc_addr mismatch: expected 0x%05h, got 0x%05h",
                         want.addr, rsp_alloc_addr);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_grant(req_func, req_size, req_block_addr);
         end
      end
      pending <= expected_grants.size();
   end

endmodule

/* tb/sv/size_class_block_allocator_tb.sv */
// ----------------------------------------------------------------------------
// size_class_block_allocator_tb
// Drives allocate, free and clear requests into the allocator: a directed
// opening over the size extremes and special codes, then phases of random
// traffic that free blocks the allocator handed out, plus phases that run
// the chunk pool dry. A checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module size_class_block_allocator_tb;
   import scba_pkg::*;

   localparam int ITEM_TARGET = 1750;
   localparam int QUIET_TAIL  = 200;

   // request code with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } live_block_type;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [SIZE_W-1:0] size;
   } issued_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [FUNC_W-1:0]   req_func;
   logic [SIZE_W-1:0]   req_size;
   logic [ADDR_W-1:0]   req_block_addr;
   logic                rsp_valid;
   logic [ADDR_W-1:0]   rsp_alloc_addr;
   logic [STATUS_W-1:0] rsp_status;
   int                  check_errors;
   int                  pending;

   live_block_type live_blocks[$];
   issued_type     in_flight[$];
   bit             gaps_on;
   int             useful_sent;
   int             granted_cnt, freed_cnt, cleared_cnt;
   int             zero_cnt, oversize_cnt, no_chunk_cnt, unused_cnt;

   always #6 clock = ~clock;

   size_class_block_allocator u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_size       (req_size),
      .req_block_addr (req_block_addr),
      .rsp_valid      (rsp_valid),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_status     (rsp_status)
   );

   scba_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_size       (req_size),
      .req_block_addr (req_block_addr),
      .rsp_valid      (rsp_valid),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_status     (rsp_status),
      .errors         (check_errors),
      .pending        (pending)
   );

   // Track granted blocks mid-cycle so that frees can target them; the
   // values seen here are the ones the next rising edge will transfer.
   always @(negedge clock) begin
      issued_type req;
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1 && in_flight.size() != 0) begin
            req = in_flight.pop_front();
            case (rsp_status)
               STATUS_ZERO:     zero_cnt++;
               STATUS_OVERSIZE: oversize_cnt++;
               STATUS_NO_CHUNK: no_chunk_cnt++;
               default: begin
                  if (req.func == FUNC_ALLOC) begin
                     granted_cnt++;
                     live_blocks.push_back('{rsp_alloc_addr, req.size});
                  end else if (req.func == FUNC_FREE) begin
                     freed_cnt++;
                  end else if (req.func == FUNC_CLEAR) begin
                     cleared_cnt++;
                     live_blocks.delete();
                  end else begin
                     unused_cnt++;
                  end
               end
            endcase
         end
         if (start && !busy) begin
            in_flight.push_back('{req_func, req_size});
         end
      end
   end

   task automatic issue(input logic [FUNC_W-1:0] func, input logic [SIZE_W-1:0] size,
                        input logic [ADDR_W-1:0] baddr);
      start          <= 1'b1;
      req_func       <= func;
      req_size       <= size;
      req_block_addr <= baddr;
      do @(posedge clock); while (busy);
      if (func == FUNC_CLEAR ||
          ((func == FUNC_ALLOC || func == FUNC_FREE) && size != 0 && size <= MAX_BLOCK_BYTES)) begin
         useful_sent++;
      end
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // hold off the sender until every response is back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int k;
      k = $urandom_range(0, NUM_CLASSES - 1);
      case ($urandom_range(0, 3))
         0:       return SIZE_W'(class_bytes(CLASS_W'(k)));
         1:       return (k == NUM_CLASSES - 1) ? SIZE_W'(1)
                                                : SIZE_W'(class_bytes(CLASS_W'(k)) + 1);
         2:       return SIZE_W'($urandom_range(1, 64));
         default: return SIZE_W'($urandom_range(1, MAX_BLOCK_BYTES));
      endcase
   endfunction

   task automatic free_live();
      int             idx;
      live_block_type blk;
      if (live_blocks.size() == 0) begin
         issue(FUNC_ALLOC, pick_size(), ADDR_W'($urandom));
      end else begin
         idx = $urandom_range(0, live_blocks.size() - 1);
         blk = live_blocks[idx];
         live_blocks.delete(idx);
         issue(FUNC_FREE, blk.size, blk.addr);
      end
   endtask

   task automatic random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         issue(FUNC_ALLOC, pick_size(), ADDR_W'($urandom));
      end else if (r < 85) begin
         free_live();
      end else if (r < 90) begin
         // stray free of an arbitrary address
         issue(FUNC_FREE, SIZE_W'($urandom_range(1, MAX_BLOCK_BYTES)), ADDR_W'($urandom));
      end else if (r < 94) begin
         issue($urandom_range(0, 1) ? FUNC_FREE : FUNC_ALLOC, '0, ADDR_W'($urandom));
      end else if (r < 97) begin
         issue($urandom_range(0, 1) ? FUNC_FREE : FUNC_ALLOC,
               SIZE_W'($urandom_range(MAX_BLOCK_BYTES + 1, 65535)), ADDR_W'($urandom));
      end else if (r < 98) begin
         issue(FUNC_UNUSED, SIZE_W'($urandom), ADDR_W'($urandom));
      end else begin
         issue(FUNC_CLEAR, SIZE_W'($urandom), ADDR_W'($urandom));
      end
   endtask

   // open a chunk for every class, then hammer the largest class until
   // the pool runs out
   task automatic exhaust_pool();
      int lo;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         lo = (k == 0) ? 1 : int'(class_bytes(CLASS_W'(k - 1))) + 1;
         issue(FUNC_ALLOC, SIZE_W'($urandom_range(lo, class_bytes(CLASS_W'(k)))),
               ADDR_W'($urandom));
      end
      repeat (110) begin
         if ($urandom_range(0, 9) != 0) begin
            issue(FUNC_ALLOC, SIZE_W'($urandom_range(513, MAX_BLOCK_BYTES)), ADDR_W'($urandom));
         end else begin
            free_live();
         end
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_func       <= FUNC_ALLOC;
      req_size       <= '0;
      req_block_addr <= '0;
      useful_sent    = 0;
      gaps_on        = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      issue(FUNC_ALLOC, 16'd1, '0);
      issue(FUNC_ALLOC, 16'd16, '0);
      issue(FUNC_ALLOC, 16'd17, '1);
      issue(FUNC_ALLOC, 16'd640, '0);
      issue(FUNC_ALLOC, 16'd641, '0);
      issue(FUNC_ALLOC, 16'hFFFF, '1);
      issue(FUNC_FREE, 16'hFFFF, '1);
      issue(FUNC_ALLOC, 16'd0, '1);
      issue(FUNC_FREE, 16'd0, '1);
      issue(FUNC_UNUSED, 16'hFFFF, '1);
      issue(FUNC_FREE, 16'd16, 18'd16);
      issue(FUNC_FREE, 16'd1, 18'd0);
      issue(FUNC_ALLOC, 16'd8, '0);
      issue(FUNC_ALLOC, 16'd16, '0);
      issue(FUNC_ALLOC, 16'd16, '0);
      issue(FUNC_FREE, 16'd640, 18'h3FFC0);
      issue(FUNC_ALLOC, 16'd600, '0);
      issue(FUNC_CLEAR, 16'hFFFF, '1);
      issue(FUNC_ALLOC, 16'd640, '0);
      issue(FUNC_ALLOC, 16'd320, '0);
      issue(FUNC_ALLOC, 16'd321, '0);
      drain();
      issue(FUNC_CLEAR, '0, '0);

      while (useful_sent < ITEM_TARGET) begin
         gaps_on = (useful_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         if (useful_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            exhaust_pool();
         end else begin
            repeat ($urandom_range(100, 200)) random_request();
         end
         drain();
         issue(FUNC_CLEAR, SIZE_W'($urandom), ADDR_W'($urandom));
      end

      start <= 1'b0;
      @(posedge clock);
      for (int w = 0; w < 1000 && pending != 0; w++) @(posedge clock);
      repeat (8) @(posedge clock);

      if (pending != 0) begin
         $error("%0d expected responses never arrived", pending);
      end
      $display("Covered %0d requests: %0d blocks granted, %0d frees, %0d clears",
               useful_sent, granted_cnt, freed_cnt, cleared_cnt);
      $display("Rejected: %0d zero size, %0d oversize, %0d out of chunks; %0d unused codes",
               zero_cnt, oversize_cnt, no_chunk_cnt, unused_cnt);
      if (check_errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #1500000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
